FILE: design/antialiased_line_coverage_top_macros.svh
// Assertion macros used by the checker file of the line coverage block.
`ifndef ANTIALIASED_LINE_COVERAGE_TOP_MACROS_SVH
`define ANTIALIASED_LINE_COVERAGE_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ALC_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("line coverage check failed");

// Check that a condition implies a consequence in the next cycle.
`define ALC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("line coverage check failed");

`endif

FILE: design/alc_pkg.sv
// Package with shared types, constants and sample offsets of the line coverage block.
package alc_pkg;

	localparam int UNITS    = 8;
	localparam int SUB_GRID = 8;
	localparam int PICK     = 5;
	localparam int SAMPLES  = (SUB_GRID * SUB_GRID + PICK - 1) / PICK;
	localparam int MAX_SIZE = 1024;

	localparam int COORD_W  = 13;
	localparam int DIFF_W   = 14;
	localparam int SQ_W     = 28;
	localparam int DOT_W    = 30;
	localparam int VALUE_W  = 16;
	localparam int CNT_W    = 4;

	// Reciprocal of the used sample count for the final scaling
	localparam int          DIV_SHIFT = 24;
	localparam logic [20:0] DIV_RECIP = 21'd1290556;

	// Register indexes
	localparam logic [2:0] REG_SIZE  = 3'd0;
	localparam logic [2:0] REG_SX    = 3'd1;
	localparam logic [2:0] REG_SY    = 3'd2;
	localparam logic [2:0] REG_EX    = 3'd3;
	localparam logic [2:0] REG_EY    = 3'd4;
	localparam logic [2:0] REG_THICK = 3'd5;

	typedef struct packed {
		logic [COORD_W-1:0] ax;
		logic [COORD_W-1:0] ay;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by;
	} geom_t;

	typedef struct packed {
		logic [SQ_W-1:0]     len2;
		logic [SQ_W-1:0]     t2;
		logic [2*SQ_W-1:0]   t2len2;
	} limits_t;

	typedef struct packed {
		logic [2:0] col;
		logic [2:0] row;
	} offset_t;

	// Sub-sample offset of the i-th used sample, in 1/8-pixel units
	function automatic offset_t sample_offset(input int i);
		int idx;
		offset_t o;
		idx = i * PICK;
		o.col = 3'(((idx % SUB_GRID) * UNITS) / SUB_GRID);
		o.row = 3'(((idx / SUB_GRID) * UNITS) / SUB_GRID);
		return o;
	endfunction

endpackage

FILE: design/antialiased_line_coverage_top.sv
// Top level of the anti-aliased thick line coverage block.
// One pixel is accepted per cycle, stalling only while the output item is not taken.
// The block has six register stages: endpoint differences, dot/cross products,
// region select with the cross-product square, the coverage compare across 13
// parallel sample testers, value weighting, and division by 13 through a
// reciprocal multiply, the last of which drives the outputs. Write configuration
// only while no pixel is in flight.
module antialiased_line_coverage_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	input  logic [15:0] current_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  out_x,
	output logic [9:0]  out_y,
	output logic [15:0] new_value,
	output logic        in_circle,
	output logic [3:0]  outside_samples
);

	logic [10:0] image_size_q;
	logic [12:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [13:0] thickness_q;
	logic [10:0] size;
	alc_pkg::geom_t   geom;
	alc_pkg::limits_t lim_q;
	logic signed [13:0] abx, aby;
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [19:0] pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6;
	logic [15:0] cur_s1, cur_s2, cur_s3, cur_s4;
	logic signed [12:0] dx, dy;
	logic [23:0] dsq_s2;
	logic [21:0] ssq_s2;
	logic inside_s3, inside_s4;
	logic [alc_pkg::SAMPLES-1:0] clear_s4;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= 11'd512;
			start_x_q    <= '0;
			start_y_q    <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			thickness_q  <= 14'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				alc_pkg::REG_SIZE:  image_size_q <= cfg_data[10:0];
				alc_pkg::REG_SX:    start_x_q    <= cfg_data[12:0];
				alc_pkg::REG_SY:    start_y_q    <= cfg_data[12:0];
				alc_pkg::REG_EX:    end_x_q      <= cfg_data[12:0];
				alc_pkg::REG_EY:    end_y_q      <= cfg_data[12:0];
				alc_pkg::REG_THICK: thickness_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derive segment limits from the settled configuration
	assign abx = $signed({1'b0, end_x_q}) - $signed({1'b0, start_x_q});
	assign aby = $signed({1'b0, end_y_q}) - $signed({1'b0, start_y_q});

	always_ff @(posedge clk) begin
		lim_q.len2   <= 28'(abx * abx) + 28'(aby * aby);
		lim_q.t2     <= thickness_q * thickness_q;
		lim_q.t2len2 <= lim_q.t2 * lim_q.len2;
	end

	assign geom.ax = start_x_q;
	assign geom.ay = start_y_q;
	assign geom.bx = end_x_q;
	assign geom.by = end_y_q;

	assign size = (image_size_q > 11'(alc_pkg::MAX_SIZE)) ? 11'(alc_pkg::MAX_SIZE) : image_size_q;

	// Advance the whole pipe unless the output item is stuck
	assign adv      = !v_s6 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Carry pixel and value down the pipe
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= {pixel_y, pixel_x};
			pix_s2 <= pix_s1;
			pix_s3 <= pix_s2;
			pix_s4 <= pix_s3;
			pix_s5 <= pix_s4;
			pix_s6 <= pix_s5;
			cur_s1 <= current_value;
			cur_s2 <= cur_s1;
			cur_s3 <= cur_s2;
			cur_s4 <= cur_s3;
		end
	end

	// Circle test: squares, then compare
	assign dx = $signed({2'b00, pix_s1[9:0], 1'b0}) - $signed({2'b00, size});
	assign dy = $signed({2'b00, pix_s1[19:10], 1'b0}) - $signed({2'b00, size});

	always_ff @(posedge clk) begin
		if (adv) begin
			dsq_s2    <= 24'(dx * dx) + 24'(dy * dy);
			ssq_s2    <= size * size;
			inside_s3 <= dsq_s2 < {2'b00, ssq_s2};
			inside_s4 <= inside_s3;
		end
	end

	// Test every used sub-sample in parallel
	for (genvar i = 0; i < alc_pkg::SAMPLES; i++) begin : g_smp
		alc_sample u_smp (
			.clk      (clk),
			.en       (adv),
			.px       (pixel_x),
			.py       (pixel_y),
			.offs     (alc_pkg::sample_offset(i)),
			.geom     (geom),
			.lim      (lim_q),
			.clear_s4 (clear_s4[i])
		);
	end

	alc_scale u_scale (
		.clk       (clk),
		.en        (adv),
		.cur_s4    (cur_s4),
		.inside_s4 (inside_s4),
		.clear_s4  (clear_s4),
		.value_s6  (new_value),
		.inside_s6 (in_circle),
		.count_s6  (outside_samples)
	);

	assign out_valid = v_s6;
	assign out_x     = pix_s6[9:0];
	assign out_y     = pix_s6[19:10];

endmodule

FILE: design/alc_sample.sv
// One sub-sample tester: clamped projection distance test against the segment.
module alc_sample (
	input  logic                          clk,
	input  logic                          en,
	input  logic [9:0]                    px,
	input  logic [9:0]                    py,
	input  alc_pkg::offset_t              offs,
	input  alc_pkg::geom_t                geom,
	input  alc_pkg::limits_t              lim,
	output logic                          clear_s4
);

	logic [alc_pkg::COORD_W-1:0] sx, sy;
	logic signed [alc_pkg::DIFF_W-1:0] apx_s1, apy_s1, bpx_s1, bpy_s1, abx_s1, aby_s1;
	logic signed [alc_pkg::DOT_W-1:0] dot_s2, cr_s2;
	logic [alc_pkg::SQ_W-1:0] da2_s2, db2_s2, da2_s3, db2_s3;
	logic signed [2*alc_pkg::DIFF_W-1:0] m_ax, m_ay, m_cx, m_cy, q_ax, q_ay, q_bx, q_by;
	logic signed [alc_pkg::DOT_W-1:0] len2_sd;
	logic [alc_pkg::DOT_W-1:0] cr_abs;
	logic before_s3, past_s3, cov;
	logic [2*alc_pkg::SQ_W-1:0] cr2_s3;

	// Place the sample inside the pixel
	assign sx = {px, 3'b000} + alc_pkg::COORD_W'(offs.col);
	assign sy = {py, 3'b000} + alc_pkg::COORD_W'(offs.row);

	// Stage 1: differences to the endpoints
	always_ff @(posedge clk) begin
		if (en) begin
			apx_s1 <= $signed({1'b0, sx}) - $signed({1'b0, geom.ax});
			apy_s1 <= $signed({1'b0, sy}) - $signed({1'b0, geom.ay});
			bpx_s1 <= $signed({1'b0, sx}) - $signed({1'b0, geom.bx});
			bpy_s1 <= $signed({1'b0, sy}) - $signed({1'b0, geom.by});
			abx_s1 <= $signed({1'b0, geom.bx}) - $signed({1'b0, geom.ax});
			aby_s1 <= $signed({1'b0, geom.by}) - $signed({1'b0, geom.ay});
		end
	end

	// Stage 2: dot, cross and squared endpoint distances
	assign m_ax = abx_s1 * apx_s1;
	assign m_ay = aby_s1 * apy_s1;
	assign m_cx = abx_s1 * apy_s1;
	assign m_cy = aby_s1 * apx_s1;
	assign q_ax = apx_s1 * apx_s1;
	assign q_ay = apy_s1 * apy_s1;
	assign q_bx = bpx_s1 * bpx_s1;
	assign q_by = bpy_s1 * bpy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= alc_pkg::DOT_W'(m_ax) + alc_pkg::DOT_W'(m_ay);
			cr_s2  <= alc_pkg::DOT_W'(m_cx) - alc_pkg::DOT_W'(m_cy);
			da2_s2 <= q_ax + q_ay;
			db2_s2 <= q_bx + q_by;
		end
	end

	// Stage 3: pick the region and square the cross product
	assign len2_sd = $signed({2'b00, lim.len2});
	assign cr_abs  = cr_s2[alc_pkg::DOT_W-1] ? alc_pkg::DOT_W'(-cr_s2) : cr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			before_s3 <= (dot_s2 <= 0);
			past_s3   <= (dot_s2 >= len2_sd);
			cr2_s3    <= cr_abs[alc_pkg::SQ_W-1:0] * cr_abs[alc_pkg::SQ_W-1:0];
			da2_s3    <= da2_s2;
			db2_s3    <= db2_s2;
		end
	end

	// Stage 4: compare against half the thickness
	always_comb begin
		if (before_s3)
			cov = {da2_s3, 2'b00} < {2'b00, lim.t2};
		else if (past_s3)
			cov = {db2_s3, 2'b00} < {2'b00, lim.t2};
		else
			cov = {cr2_s3, 2'b00} < {2'b00, lim.t2len2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clear_s4 <= !cov;
		end
	end

endmodule

FILE: design/alc_scale.sv
// Output scaling: count uncovered samples and scale the grey value by count/13.
module alc_scale (
	input  logic                              clk,
	input  logic                              en,
	input  logic [alc_pkg::VALUE_W-1:0]       cur_s4,
	input  logic                              inside_s4,
	input  logic [alc_pkg::SAMPLES-1:0]       clear_s4,
	output logic [alc_pkg::VALUE_W-1:0]       value_s6,
	output logic                              inside_s6,
	output logic [alc_pkg::CNT_W-1:0]         count_s6
);

	logic [alc_pkg::CNT_W-1:0] cnt;
	logic [alc_pkg::CNT_W-1:0] cnt_s5;
	logic inside_s5;
	logic [alc_pkg::VALUE_W+alc_pkg::CNT_W-1:0] prod_s5;
	logic [alc_pkg::VALUE_W+alc_pkg::CNT_W+20:0] scaled;

	// Count uncovered samples
	always_comb begin
		cnt = '0;
		for (int i = 0; i < alc_pkg::SAMPLES; i++)
			cnt = cnt + alc_pkg::CNT_W'(clear_s4[i]);
	end

	// Stage 5: weight the present value
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5   <= cur_s4 * cnt;
			cnt_s5    <= cnt;
			inside_s5 <= inside_s4;
		end
	end

	// Stage 6: divide by the used count through the reciprocal
	assign scaled = prod_s5 * alc_pkg::DIV_RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			value_s6  <= inside_s5 ? scaled[alc_pkg::DIV_SHIFT+alc_pkg::VALUE_W-1:alc_pkg::DIV_SHIFT]
			                       : '1;
			count_s6  <= inside_s5 ? cnt_s5 : '0;
			inside_s6 <= inside_s5;
		end
	end

endmodule

FILE: design/alc_checker.sv
// Port-level checker for the line coverage block and its bind.
`include "antialiased_line_coverage_top_macros.svh"

module alc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] new_value,
	input logic        in_circle,
	input logic [3:0]  outside_samples
);

	`ALC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(new_value))
	`ALC_ASSERT_NOW(a_white, clk, arst_n, out_valid && !in_circle, new_value == 16'hFFFF && outside_samples == 4'd0)
	`ALC_ASSERT_NOW(a_count, clk, arst_n, out_valid, outside_samples <= 4'd13)
	`ALC_ASSERT_NOW(a_black, clk, arst_n, out_valid && in_circle && outside_samples == 4'd0, new_value == 16'd0)

endmodule

bind antialiased_line_coverage_top alc_checker u_alc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.new_value       (new_value),
	.in_circle       (in_circle),
	.outside_samples (outside_samples)
);

FILE: tb/antialiased_line_coverage_top_tb.sv
// Testbench for the line coverage block: predicts each pixel result and checks all of its fields.
module antialiased_line_coverage_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [15:0] value;
		logic        circle;
		logic [3:0]  clear;
	} shade_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [15:0] current_value;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  out_x;
	logic [9:0]  out_y;
	logic [15:0] new_value;
	logic        in_circle;
	logic [3:0]  outside_samples;

	// Shadow copy of the line registers
	longint img_size, ax, ay, bx, by, thick;

	shade_t expected_shades[$];
	int     mismatches;
	bit     calm;
	int     hold_cycles;

	antialiased_line_coverage_top u_dut (.*);

	always #10 clk = ~clk;

	// Sample test: strictly within half the thickness of the segment
	function automatic bit sample_covered(longint sx, longint sy);
		longint apx, apy, abx, aby, len2, dot, t2, cr, px, py;
		apx = sx - ax; apy = sy - ay;
		abx = bx - ax; aby = by - ay;
		len2 = abx * abx + aby * aby;
		dot = abx * apx + aby * apy;
		t2 = thick * thick;
		if (dot <= 0)
			return 4 * (apx * apx + apy * apy) < t2;
		if (dot >= len2) begin
			px = sx - bx; py = sy - by;
			return 4 * (px * px + py * py) < t2;
		end
		cr = abx * apy - aby * apx;
		return 4 * (cr * cr) < t2 * len2;
	endfunction

	function automatic shade_t shade_pixel(logic [9:0] x, logic [9:0] y, logic [15:0] cur);
		shade_t s;
		longint sz, dx, dy, clr;
		s.x = x; s.y = y;
		sz = (img_size > alc_pkg::MAX_SIZE) ? alc_pkg::MAX_SIZE : img_size;
		dx = 2 * longint'(x) - sz; dy = 2 * longint'(y) - sz;
		if (dx * dx + dy * dy >= sz * sz) begin
			s.value = 16'hFFFF; s.circle = 1'b0; s.clear = '0;
			return s;
		end
		clr = 0;
		for (int c = 0; c < 8; c++)
			for (int r = 0; r < 8; r++)
				if ((r * 8 + c) % 5 == 0)
					if (!sample_covered(longint'(x) * 8 + c, longint'(y) * 8 + r))
						clr++;
		s.value = 16'((longint'(cur) * clr) / 13);
		s.circle = 1'b1;
		s.clear = 4'(clr);
		return s;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [13:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			alc_pkg::REG_SIZE:  img_size = val & 14'h7FF;
			alc_pkg::REG_SX:    ax = val & 14'h1FFF;
			alc_pkg::REG_SY:    ay = val & 14'h1FFF;
			alc_pkg::REG_EX:    bx = val & 14'h1FFF;
			alc_pkg::REG_EY:    by = val & 14'h1FFF;
			alc_pkg::REG_THICK: thick = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_line(int sz, int sx, int sy, int ex, int ey, int th);
		write_reg(alc_pkg::REG_SIZE, 14'(sz));
		write_reg(alc_pkg::REG_SX, 14'(sx));
		write_reg(alc_pkg::REG_SY, 14'(sy));
		write_reg(alc_pkg::REG_EX, 14'(ex));
		write_reg(alc_pkg::REG_EY, 14'(ey));
		write_reg(alc_pkg::REG_THICK, 14'(th));
	endtask

	// Offer one pixel, with an optional random gap before it
	task automatic send_pixel(logic [9:0] x, logic [9:0] y, logic [15:0] cur);
		if (!calm && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1; pixel_x <= x; pixel_y <= y; current_value <= cur;
		expected_shades = {expected_shades, shade_pixel(x, y, cur)};
		do @(posedge clk); while (!in_ready);
	endtask

	// Wait for the pipe to drain before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_shades.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		set_line(16, 8, 8, 100, 100, 16);
		send_pixel(10'd0, 10'd0, 16'hFFFF);
		send_pixel(10'd8, 10'd8, 16'hFFFF);
		send_pixel(10'd1, 10'd1, 16'hFFFF);
		send_pixel(10'd5, 10'd5, 16'h0000);
		send_pixel(10'd8, 10'd2, 16'h8001);
		send_pixel(10'd12, 10'd12, 16'hFFFF);
		send_pixel(10'd1023, 10'd1023, 16'h1234);
		send_pixel(10'd4, 10'd10, 16'hAAAA);
		drain();
		// degenerate segment and zero thickness
		set_line(16, 64, 64, 64, 64, 20);
		send_pixel(10'd8, 10'd8, 16'hFFFF);
		send_pixel(10'd7, 10'd7, 16'h5555);
		drain();
		write_reg(alc_pkg::REG_THICK, 14'd0);
		send_pixel(10'd8, 10'd8, 16'hFFFF);
		drain();
		// zero size, oversize, widest thickness, index beyond the list
		set_line(0, 0, 0, 8191, 8191, 16383);
		send_pixel(10'd0, 10'd0, 16'hFFFF);
		drain();
		write_reg(3'd6, 14'h3FFF);
		write_reg(3'd7, 14'h0);
		write_reg(alc_pkg::REG_SIZE, 14'd2047);
		send_pixel(10'd512, 10'd512, 16'hFFFF);
		send_pixel(10'd1, 10'd512, 16'hFFFF);
		send_pixel(10'd1023, 10'd511, 16'h7FFF);
		drain();
	endtask

	task automatic test_random(int n);
		int sz;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				drain();
				sz = ($urandom_range(3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
				set_line(sz, $urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 8191), $urandom_range(0, 8191),
					($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 400));
				// keep some segments inside the image
				if ($urandom_range(1) == 0) begin
					sz = (img_size == 0) ? 1 : ((img_size > 1024) ? 1024 : int'(img_size));
					set_line(sz, $urandom_range(0, sz * 8), $urandom_range(0, sz * 8),
						$urandom_range(0, sz * 8), $urandom_range(0, sz * 8),
						$urandom_range(0, sz * 2));
				end
			end
			if ($urandom_range(9) == 0)
				send_pixel(10'($urandom), 10'($urandom), 16'($urandom));
			else begin
				sz = (img_size == 0) ? 1 : ((img_size > 1024) ? 1024 : int'(img_size));
				send_pixel(10'($urandom_range(0, sz - 1)), 10'($urandom_range(0, sz - 1)),
					16'($urandom));
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		set_line(64, 0, 0, 512, 512, 40);
		hold_cycles = 60;
		for (int i = 0; i < 40; i++)
			send_pixel(10'($urandom_range(0, 63)), 10'($urandom_range(0, 63)), 16'($urandom));
		drain();
	endtask

	// Receiver: random stalls, plus a long hold on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (!calm && $urandom_range(5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		shade_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_x, out_y, new_value, in_circle, outside_samples};
			if (expected_shades.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: x=%0d y=%0d", out_x, out_y);
			end else begin
				want = expected_shades.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%0d y=%0d v=%0d c=%0d n=%0d got x=%0d y=%0d v=%0d c=%0d n=%0d",
							want.x, want.y, want.value, want.circle, want.clear,
							got.x, got.y, got.value, got.circle, got.clear);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("antialiased_line_coverage_top test failed");
		$finish;
	end

	initial begin
		clk = 1'b0; arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; pixel_x = '0; pixel_y = '0; current_value = '0;
		mismatches = 0; calm = 1'b0; hold_cycles = 0;
		img_size = 512; ax = 0; ay = 0; bx = 0; by = 0; thick = 8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1300);
		calm = 1'b1;
		test_random(200);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_shades.size() == 0)
			$display("antialiased_line_coverage_top test passed");
		else
			$display("antialiased_line_coverage_top test failed");
		$finish;
	end
endmodule
